// ===== rtl/assert_macros.svh =====
// Assertion helpers for the SD init sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SDCI_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sdci assertion failed");

`define SDCI_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("sdci assertion failed");

`else

`define SDCI_ASSERT(label, clk, rst_n, prop)
`define SDCI_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== rtl/sdci_pkg.sv =====
package sdci_pkg;

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_CMD0   = 4'd1;
    localparam logic [3:0] PH_CMD8   = 4'd2;
    localparam logic [3:0] PH_CMD55  = 4'd3;
    localparam logic [3:0] PH_ACMD41 = 4'd4;
    localparam logic [3:0] PH_TICK   = 4'd5;
    localparam logic [3:0] PH_CMD2   = 4'd6;
    localparam logic [3:0] PH_CMD3   = 4'd7;
    localparam logic [3:0] PH_CMD7   = 4'd8;
    localparam logic [3:0] PH_CMD16  = 4'd9;
    localparam logic [3:0] PH_CMD55W = 4'd10;
    localparam logic [3:0] PH_ACMD6  = 4'd11;
    localparam logic [3:0] PH_DONE   = 4'd12;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_RESP  = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_CRC     = 2'd2;
    localparam logic [1:0] ST_BAD     = 2'd3;

    localparam logic [1:0] RK_NONE    = 2'd0;
    localparam logic [1:0] RK_SHORT   = 2'd1;
    localparam logic [1:0] RK_NOCRC   = 2'd2;
    localparam logic [1:0] RK_LONG    = 2'd3;

    localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
    localparam logic [5:0] CMD_ALL_CID    = 6'd2;
    localparam logic [5:0] CMD_SEND_RCA   = 6'd3;
    localparam logic [5:0] CMD_SET_WIDTH  = 6'd6;
    localparam logic [5:0] CMD_SELECT     = 6'd7;
    localparam logic [5:0] CMD_IF_COND    = 6'd8;
    localparam logic [5:0] CMD_BLOCKLEN   = 6'd16;
    localparam logic [5:0] CMD_OP_COND    = 6'd41;
    localparam logic [5:0] CMD_APP        = 6'd55;

    localparam logic [31:0] OCR_ARG      = 32'h40FF_8000;
    localparam logic [31:0] IF_ARG       = 32'h0000_01AA;
    localparam logic [31:0] SECTOR_BYTES = 32'd512;
    localparam logic [31:0] WIDTH4_ARG   = 32'd2;
    localparam int          OCR_READY_BIT = 31;
    localparam int          OCR_CCS_BIT   = 30;

    localparam logic [15:0] RETRY_LIMIT_RESET = 16'd1000;

    localparam logic       CFG_RETRY_LIMIT = 1'b0;
    localparam logic       CFG_WIDE_BUS    = 1'b1;

    typedef struct packed {
        logic [15:0] retry_limit;
        logic        want_wide_bus;
    } sdci_cfg_t;

    typedef struct packed {
        logic [3:0]  phase;
        logic [15:0] retries_left;
        logic        hc_flag;
        logic [15:0] rel_address;
        logic        wide_flag;
        logic        init_done;
    } sdci_state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  resp_status;
        logic [31:0] resp_word;
    } sdci_req_t;

    typedef struct packed {
        logic        cmd_valid;
        logic [5:0]  cmd_index;
        logic [31:0] cmd_arg;
        logic [1:0]  resp_kind;
        logic        wait_tick;
        logic        done_res;
        logic [1:0]  status;
        logic        high_capacity;
        logic        wide_bus;
        logic [15:0] card_address;
    } sdci_rsp_t;

endpackage

// ===== rtl/sdci_req_if.sv =====
interface sdci_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [1:0]  resp_status;
    logic [31:0] resp_word;

    modport source (output valid, output mode, output resp_status, output resp_word,
                    input ready);
    modport sink (input valid, input mode, input resp_status, input resp_word,
                  output ready);
endinterface

// ===== rtl/sdci_rsp_if.sv =====
interface sdci_rsp_if;
    logic        valid;
    logic        ready;
    logic        cmd_valid;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [1:0]  resp_kind;
    logic        wait_tick;
    logic        done_res;
    logic [1:0]  status;
    logic        high_capacity;
    logic        wide_bus;
    logic [15:0] card_address;

    modport source (output valid, output cmd_valid, output cmd_index, output cmd_arg,
                    output resp_kind, output wait_tick, output done_res, output status,
                    output high_capacity, output wide_bus, output card_address,
                    input ready);
    modport sink (input valid, input cmd_valid, input cmd_index, input cmd_arg,
                  input resp_kind, input wait_tick, input done_res, input status,
                  input high_capacity, input wide_bus, input card_address,
                  output ready);
endinterface

// ===== rtl/sdci_step.sv =====
module sdci_step
    import sdci_pkg::*;
(
    input  sdci_state_t state,
    input  sdci_cfg_t   cfg,
    input  sdci_req_t   req,
    output sdci_state_t state_next,
    output sdci_rsp_t   rsp
);

    logic [15:0] retries_dec;
    logic [15:0] rca_new;

    assign retries_dec = state.retries_left - 16'd1;
    assign rca_new     = req.resp_word[31:16];

    always_comb
    begin
        state_next = state;
        rsp        = '0;

        case (req.mode)
            MODE_START:
            begin
                if (state.init_done)
                begin
                    rsp.done_res = 1'b1;
                    rsp.status   = ST_OK;
                end
                else
                begin
                    state_next.hc_flag      = 1'b0;
                    state_next.wide_flag    = 1'b0;
                    state_next.rel_address  = '0;
                    state_next.retries_left = (cfg.retry_limit != '0) ? cfg.retry_limit
                                                                      : 16'd1;
                    state_next.phase        = PH_CMD0;
                    rsp.cmd_valid           = 1'b1;
                    rsp.cmd_index           = CMD_GO_IDLE;
                    rsp.resp_kind           = RK_NONE;
                end
            end
            MODE_TICK:
            begin
                if (state.phase == PH_TICK)
                begin
                    state_next.phase = PH_CMD55;
                    rsp.cmd_valid    = 1'b1;
                    rsp.cmd_index    = CMD_APP;
                    rsp.resp_kind    = RK_SHORT;
                end
            end
            MODE_RESP:
            begin
                case (state.phase)
                    PH_CMD0:
                    begin
                        if (req.resp_status != ST_OK)
                        begin
                            state_next.phase = PH_IDLE;
                            rsp.done_res     = 1'b1;
                            rsp.status       = (req.resp_status == ST_CRC) ? ST_CRC
                                                                           : ST_TIMEOUT;
                        end
                        else
                        begin
                            state_next.phase = PH_CMD8;
                            rsp.cmd_valid    = 1'b1;
                            rsp.cmd_index    = CMD_IF_COND;
                            rsp.cmd_arg      = IF_ARG;
                            rsp.resp_kind    = RK_SHORT;
                        end
                    end
                    PH_CMD8:
                    begin
                        state_next.phase = PH_CMD55;
                        rsp.cmd_valid    = 1'b1;
                        rsp.cmd_index    = CMD_APP;
                        rsp.resp_kind    = RK_SHORT;
                    end
                    PH_CMD55:
                    begin
                        state_next.phase = PH_ACMD41;
                        rsp.cmd_valid    = 1'b1;
                        rsp.cmd_index    = CMD_OP_COND;
                        rsp.cmd_arg      = OCR_ARG;
                        rsp.resp_kind    = RK_NOCRC;
                    end
                    PH_ACMD41:
                    begin
                        // no crc on R3, so a crc failure counts as ok
                        if (req.resp_status == ST_TIMEOUT || req.resp_status == ST_BAD)
                        begin
                            state_next.phase = PH_IDLE;
                            rsp.done_res     = 1'b1;
                            rsp.status       = ST_TIMEOUT;
                        end
                        else if (req.resp_word[OCR_READY_BIT])
                        begin
                            state_next.hc_flag = req.resp_word[OCR_CCS_BIT];
                            state_next.phase   = PH_CMD2;
                            rsp.cmd_valid      = 1'b1;
                            rsp.cmd_index      = CMD_ALL_CID;
                            rsp.resp_kind      = RK_LONG;
                        end
                        else
                        begin
                            state_next.retries_left = retries_dec;
                            if (retries_dec == '0)
                            begin
                                state_next.phase = PH_IDLE;
                                rsp.done_res     = 1'b1;
                                rsp.status       = ST_TIMEOUT;
                            end
                            else
                            begin
                                state_next.phase = PH_TICK;
                                rsp.wait_tick    = 1'b1;
                            end
                        end
                    end
                    PH_CMD2:
                    begin
                        state_next.phase = PH_CMD3;
                        rsp.cmd_valid    = 1'b1;
                        rsp.cmd_index    = CMD_SEND_RCA;
                        rsp.resp_kind    = RK_SHORT;
                    end
                    PH_CMD3:
                    begin
                        state_next.rel_address = rca_new;
                        state_next.phase       = PH_CMD7;
                        rsp.cmd_valid          = 1'b1;
                        rsp.cmd_index          = CMD_SELECT;
                        rsp.cmd_arg            = {rca_new, 16'h0000};
                        rsp.resp_kind          = RK_SHORT;
                    end
                    PH_CMD7, PH_CMD16:
                    begin
                        if (state.phase == PH_CMD7 && !state.hc_flag)
                        begin
                            state_next.phase = PH_CMD16;
                            rsp.cmd_valid    = 1'b1;
                            rsp.cmd_index    = CMD_BLOCKLEN;
                            rsp.cmd_arg      = SECTOR_BYTES;
                            rsp.resp_kind    = RK_SHORT;
                        end
                        else if (cfg.want_wide_bus)
                        begin
                            state_next.phase = PH_CMD55W;
                            rsp.cmd_valid    = 1'b1;
                            rsp.cmd_index    = CMD_APP;
                            rsp.cmd_arg      = {state.rel_address, 16'h0000};
                            rsp.resp_kind    = RK_SHORT;
                        end
                        else
                        begin
                            state_next.init_done = 1'b1;
                            state_next.phase     = PH_DONE;
                            rsp.done_res         = 1'b1;
                            rsp.status           = ST_OK;
                        end
                    end
                    PH_CMD55W:
                    begin
                        if (req.resp_status == ST_OK)
                        begin
                            state_next.phase = PH_ACMD6;
                            rsp.cmd_valid    = 1'b1;
                            rsp.cmd_index    = CMD_SET_WIDTH;
                            rsp.cmd_arg      = WIDTH4_ARG;
                            rsp.resp_kind    = RK_SHORT;
                        end
                        else
                        begin
                            state_next.init_done = 1'b1;
                            state_next.phase     = PH_DONE;
                            rsp.done_res         = 1'b1;
                            rsp.status           = ST_OK;
                        end
                    end
                    PH_ACMD6:
                    begin
                        if (req.resp_status == ST_OK)
                        begin
                            state_next.wide_flag = 1'b1;
                        end
                        state_next.init_done = 1'b1;
                        state_next.phase     = PH_DONE;
                        rsp.done_res         = 1'b1;
                        rsp.status           = ST_OK;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        rsp.high_capacity = state_next.hc_flag;
        rsp.wide_bus      = state_next.wide_flag;
        rsp.card_address  = state_next.rel_address;
    end

endmodule

// ===== rtl/sd_card_init_sequencer.sv =====
// SD card bring-up sequencer, command level.
// Results are registered at the input transfer; the sequence state updates there too.
// Throughput: one item per cycle unless a pending result is held off by rsp_ch.ready.
// Reset (rst_n, async, active low): phase idle, flags and card address clear,
// retry limit 1000, wide bus off, no result pending.
`include "assert_macros.svh"

module sd_card_init_sequencer
    import sdci_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    sdci_req_if.sink    req_ch,
    sdci_rsp_if.source  rsp_ch
);

    sdci_cfg_t   cfg_reg;
    sdci_state_t state_reg;
    sdci_state_t state_next;
    sdci_req_t   req;
    sdci_rsp_t   rsp_next;
    sdci_rsp_t   rsp_item_reg;
    logic        rsp_valid_reg;
    logic        req_xfer;

    assign req.mode        = req_ch.mode;
    assign req.resp_status = req_ch.resp_status;
    assign req.resp_word   = req_ch.resp_word;

    assign req_ch.ready = !rsp_valid_reg || rsp_ch.ready;
    assign req_xfer     = req_ch.valid && req_ch.ready;

    sdci_step u_step (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .req        (req),
        .state_next (state_next),
        .rsp        (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.retry_limit   <= RETRY_LIMIT_RESET;
            cfg_reg.want_wide_bus <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RETRY_LIMIT: cfg_reg.retry_limit   <= cfg_wdata;
                CFG_WIDE_BUS:    cfg_reg.want_wide_bus <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase        <= PH_IDLE;
            state_reg.retries_left <= '0;
            state_reg.hc_flag      <= 1'b0;
            state_reg.rel_address  <= '0;
            state_reg.wide_flag    <= 1'b0;
            state_reg.init_done    <= 1'b0;
            rsp_valid_reg          <= 1'b0;
        end
        else
        begin
            if (req_xfer)
            begin
                state_reg <= state_next;
            end
            if (req_xfer)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ch.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            rsp_item_reg <= rsp_next;
        end
    end

    assign rsp_ch.valid         = rsp_valid_reg;
    assign rsp_ch.cmd_valid     = rsp_item_reg.cmd_valid;
    assign rsp_ch.cmd_index     = rsp_item_reg.cmd_index;
    assign rsp_ch.cmd_arg       = rsp_item_reg.cmd_arg;
    assign rsp_ch.resp_kind     = rsp_item_reg.resp_kind;
    assign rsp_ch.wait_tick     = rsp_item_reg.wait_tick;
    assign rsp_ch.done_res      = rsp_item_reg.done_res;
    assign rsp_ch.status        = rsp_item_reg.status;
    assign rsp_ch.high_capacity = rsp_item_reg.high_capacity;
    assign rsp_ch.wide_bus      = rsp_item_reg.wide_bus;
    assign rsp_ch.card_address  = rsp_item_reg.card_address;

    `SDCI_ASSERT(a_xfer_gives_result, clk, rst_n, req_xfer |=> rsp_valid_reg)
    `SDCI_ASSERT(a_cmd_not_done, clk, rst_n,
        (rsp_valid_reg && rsp_item_reg.cmd_valid) |-> !rsp_item_reg.done_res)
    `SDCI_ASSERT_ALWAYS(a_done_phase, clk,
        state_reg.init_done |-> (state_reg.phase == PH_DONE))
    `SDCI_ASSERT_ALWAYS(a_retries_live, clk,
        (state_reg.phase == PH_CMD55 || state_reg.phase == PH_ACMD41 ||
         state_reg.phase == PH_TICK) |-> (state_reg.retries_left != '0))

endmodule

// ===== tb/sdci_checker.sv =====
module sdci_checker
    import sdci_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    sdci_req_if         req_ch,
    sdci_rsp_if         rsp_ch,
    output int          mismatches,
    output int          outstanding,
    output int          results_checked
);

    logic [15:0] retry_limit;
    logic        wide_wanted;

    logic [3:0]  phase;
    logic [15:0] retries_left;
    logic        hc_flag;
    logic [15:0] rel_address;
    logic        wide_flag;
    logic        init_done;

    sdci_rsp_t   expected_replies[$];

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] seen,
                               input logic [31:0] want);
        if (seen !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      results_checked, name, seen, want));
    endtask

    function automatic sdci_rsp_t command(input logic [5:0] idx, input logic [31:0] arg,
                                          input logic [1:0] kind);
        sdci_rsp_t r;
        r = '0;
        r.cmd_valid = 1'b1;
        r.cmd_index = idx;
        r.cmd_arg = arg;
        r.resp_kind = kind;
        return r;
    endfunction

    task automatic abort_with(input logic [1:0] st, output sdci_rsp_t r);
        r = '0;
        r.done_res = 1'b1;
        r.status = st;
        phase = PH_IDLE;
    endtask

    task automatic finish_up(output sdci_rsp_t r);
        r = '0;
        r.done_res = 1'b1;
        r.status = ST_OK;
        init_done = 1'b1;
        phase = PH_DONE;
    endtask

    task automatic bus_width_or_finish(output sdci_rsp_t r);
        if (wide_wanted)
        begin
            phase = PH_CMD55W;
            r = command(CMD_APP, {rel_address, 16'h0000}, RK_SHORT);
        end
        else
            finish_up(r);
    endtask

    task automatic advance_sequencer(input logic [1:0] mode, input logic [1:0] st,
                                     input logic [31:0] word, output sdci_rsp_t r);
        r = '0;
        case (mode)
            MODE_START:
                if (init_done)
                begin
                    r.done_res = 1'b1;
                    r.status = ST_OK;
                end
                else
                begin
                    hc_flag = 1'b0;
                    wide_flag = 1'b0;
                    rel_address = '0;
                    retries_left = (retry_limit != 16'd0) ? retry_limit : 16'd1;
                    phase = PH_CMD0;
                    r = command(CMD_GO_IDLE, '0, RK_NONE);
                end
            MODE_TICK:
                if (phase == PH_TICK)
                begin
                    phase = PH_CMD55;
                    r = command(CMD_APP, '0, RK_SHORT);
                end
            MODE_RESP:
                case (phase)
                    PH_CMD0:
                        if (st != ST_OK)
                            abort_with((st == ST_CRC) ? ST_CRC : ST_TIMEOUT, r);
                        else
                        begin
                            phase = PH_CMD8;
                            r = command(CMD_IF_COND, IF_ARG, RK_SHORT);
                        end
                    PH_CMD8:
                    begin
                        phase = PH_CMD55;
                        r = command(CMD_APP, '0, RK_SHORT);
                    end
                    PH_CMD55:
                    begin
                        phase = PH_ACMD41;
                        r = command(CMD_OP_COND, OCR_ARG, RK_NOCRC);
                    end
                    PH_ACMD41:
                        if (st == ST_TIMEOUT || st == ST_BAD)
                            abort_with(ST_TIMEOUT, r);
                        else if (word[OCR_READY_BIT])
                        begin
                            hc_flag = word[OCR_CCS_BIT];
                            phase = PH_CMD2;
                            r = command(CMD_ALL_CID, '0, RK_LONG);
                        end
                        else
                        begin
                            retries_left = retries_left - 16'd1;
                            if (retries_left == 16'd0)
                                abort_with(ST_TIMEOUT, r);
                            else
                            begin
                                phase = PH_TICK;
                                r.wait_tick = 1'b1;
                            end
                        end
                    PH_CMD2:
                    begin
                        phase = PH_CMD3;
                        r = command(CMD_SEND_RCA, '0, RK_SHORT);
                    end
                    PH_CMD3:
                    begin
                        rel_address = word[31:16];
                        phase = PH_CMD7;
                        r = command(CMD_SELECT, {word[31:16], 16'h0000}, RK_SHORT);
                    end
                    PH_CMD7:
                        if (!hc_flag)
                        begin
                            phase = PH_CMD16;
                            r = command(CMD_BLOCKLEN, SECTOR_BYTES, RK_SHORT);
                        end
                        else
                            bus_width_or_finish(r);
                    PH_CMD16:
                        bus_width_or_finish(r);
                    PH_CMD55W:
                        if (st == ST_OK)
                        begin
                            phase = PH_ACMD6;
                            r = command(CMD_SET_WIDTH, WIDTH4_ARG, RK_SHORT);
                        end
                        else
                            finish_up(r);
                    PH_ACMD6:
                    begin
                        if (st == ST_OK)
                            wide_flag = 1'b1;
                        finish_up(r);
                    end
                    default: ;
                endcase
            default: ;
        endcase
        r.high_capacity = hc_flag;
        r.wide_bus = wide_flag;
        r.card_address = rel_address;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sdci_rsp_t predicted;
        sdci_rsp_t want;
        if (!rst_n)
        begin
            retry_limit = RETRY_LIMIT_RESET;
            wide_wanted = 1'b0;
            phase = PH_IDLE;
            retries_left = '0;
            hc_flag = 1'b0;
            rel_address = '0;
            wide_flag = 1'b0;
            init_done = 1'b0;
            expected_replies.delete();
            mismatches = 0;
            outstanding = 0;
            results_checked = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_RETRY_LIMIT)
                    retry_limit = cfg_wdata;
                else
                    wide_wanted = cfg_wdata[0];
            end
            if (req_ch.valid && req_ch.ready)
            begin
                advance_sequencer(req_ch.mode, req_ch.resp_status, req_ch.resp_word,
                                  predicted);
                expected_replies.push_back(predicted);
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_replies.size() == 0)
                    report_mismatch("result transfer with nothing expected");
                else
                begin
                    want = expected_replies.pop_front();
                    check_field("cmd_valid", 32'(rsp_ch.cmd_valid), 32'(want.cmd_valid));
                    check_field("cmd_index", 32'(rsp_ch.cmd_index), 32'(want.cmd_index));
                    check_field("cmd_arg", rsp_ch.cmd_arg, want.cmd_arg);
                    check_field("resp_kind", 32'(rsp_ch.resp_kind), 32'(want.resp_kind));
                    check_field("wait_tick", 32'(rsp_ch.wait_tick), 32'(want.wait_tick));
                    check_field("done_res", 32'(rsp_ch.done_res), 32'(want.done_res));
                    check_field("status", 32'(rsp_ch.status), 32'(want.status));
                    check_field("high_capacity", 32'(rsp_ch.high_capacity),
                                32'(want.high_capacity));
                    check_field("wide_bus", 32'(rsp_ch.wide_bus), 32'(want.wide_bus));
                    check_field("card_address", 32'(rsp_ch.card_address),
                                32'(want.card_address));
                end
                results_checked++;
            end
            outstanding = expected_replies.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import sdci_pkg::*;

    localparam int         ITEM_TARGET = 850;
    localparam int         STALL_LIMIT = 1500;
    localparam int         HOLD_CYCLES = 120;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;

    sdci_req_if req_ch ();
    sdci_rsp_if rsp_ch ();

    int          mismatches;
    int          outstanding;
    int          results_checked;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_cycles = 0;
    int          items_sent = 0;
    int          seq_budget = 0;
    int          settings_used = 0;
    int          quiet_cycles = 0;
    bit          last_sent;
    bit          at_rest;
    logic [15:0] cur_limit = RETRY_LIMIT_RESET;
    logic        cur_wide = 1'b0;

    sd_card_init_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req_ch    (req_ch),
        .rsp_ch    (rsp_ch)
    );

    sdci_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .req_ch          (req_ch),
        .rsp_ch          (rsp_ch),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("sd_card_init_sequencer test failed");
            $finish;
        end
    end

    // result sink; a pending hold keeps ready low until hold_cycles runs down to zero
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                rsp_ch.ready = 1'b0;
                hold_cycles--;
            end
            else
                rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic feed(input logic [1:0] mode, input logic [1:0] st, input logic [31:0] word,
                        input bit counted);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.mode = mode;
        req_ch.resp_status = st;
        req_ch.resp_word = word;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (counted)
            items_sent++;
    endtask

    task automatic apply_settings(input logic [15:0] limit, input logic wide);
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = CFG_RETRY_LIMIT;
        cfg_wdata = limit;
        @(negedge clk);
        cfg_index = CFG_WIDE_BUS;
        cfg_wdata = {15'd0, wide};
        @(negedge clk);
        cfg_we = 1'b0;
        cur_limit = limit;
        cur_wide = wide;
        settings_used++;
    endtask

    // items past the budget are dropped, which cuts a bring-up short
    task automatic seq_item(input logic [1:0] mode, input logic [1:0] st,
                            input logic [31:0] word, input bit counted);
        last_sent = (seq_budget > 0);
        if (last_sent)
        begin
            if (counted)
                seq_budget--;
            feed(mode, st, word, 1'b1);
        end
    endtask

    task automatic stray_item();
        if ($urandom_range(7) == 0)
            seq_item(($urandom_range(1) != 0) ? MODE_TICK : MODE_UNUSED,
                     2'($urandom_range(3)), $urandom(), 1'b0);
    endtask

    // non-final runs never send the response that would complete the bring-up
    task automatic bring_up(input bit final_run);
        logic        hc;
        int          not_ready;
        logic [15:0] tries;
        logic [31:0] word;
        at_rest = 1'b0;
        seq_budget = final_run ? ITEM_TARGET : $urandom_range(1, 30);
        seq_item(MODE_START, 2'($urandom_range(3)), $urandom(), 1'b1);
        stray_item();
        if (!final_run && $urandom_range(7) == 0)
        begin
            seq_item(MODE_RESP, 2'($urandom_range(1, 3)), $urandom(), 1'b1);
            at_rest = last_sent;
            return;
        end
        seq_item(MODE_RESP, ST_OK, $urandom(), 1'b1);
        seq_item(MODE_RESP, 2'($urandom_range(3)), $urandom(), 1'b1);
        stray_item();
        seq_item(MODE_RESP, 2'($urandom_range(3)), $urandom(), 1'b1);
        tries = (cur_limit != 16'd0) ? cur_limit : 16'd1;
        not_ready = $urandom_range(0, 3);
        if (final_run && not_ready >= tries)
            not_ready = tries - 1;
        forever
        begin
            if (!final_run && $urandom_range(11) == 0)
            begin
                seq_item(MODE_RESP, ($urandom_range(1) != 0) ? ST_TIMEOUT : ST_BAD,
                         $urandom(), 1'b1);
                at_rest = last_sent;
                return;
            end
            if (not_ready == 0)
                break;
            not_ready--;
            word = $urandom();
            word[OCR_READY_BIT] = 1'b0;
            seq_item(MODE_RESP, ($urandom_range(1) != 0) ? ST_CRC : ST_OK, word, 1'b1);
            tries--;
            if (tries == 16'd0)
            begin
                at_rest = last_sent;
                return;
            end
            if ($urandom_range(5) == 0)
                seq_item(MODE_RESP, 2'($urandom_range(3)), $urandom(), 1'b0);
            seq_item(MODE_TICK, 2'($urandom_range(3)), $urandom(), 1'b1);
            seq_item(MODE_RESP, 2'($urandom_range(3)), $urandom(), 1'b1);
        end
        hc = 1'($urandom_range(1));
        word = $urandom();
        word[OCR_READY_BIT] = 1'b1;
        word[OCR_CCS_BIT] = hc;
        seq_item(MODE_RESP, ($urandom_range(1) != 0) ? ST_CRC : ST_OK, word, 1'b1);
        seq_item(MODE_RESP, 2'($urandom_range(3)), $urandom(), 1'b1);
        seq_item(MODE_RESP, 2'($urandom_range(3)), $urandom(), 1'b1);
        stray_item();
        if (hc && !cur_wide && !final_run)
            return;
        seq_item(MODE_RESP, 2'($urandom_range(3)), $urandom(), 1'b1);
        if (!hc)
        begin
            if (!cur_wide && !final_run)
                return;
            seq_item(MODE_RESP, 2'($urandom_range(3)), $urandom(), 1'b1);
        end
        if (!cur_wide)
            return;
        seq_item(MODE_RESP, (final_run && $urandom_range(3) == 0) ?
                 2'($urandom_range(1, 3)) : ST_OK, $urandom(), 1'b1);
        if (!final_run)
            return;
        seq_item(MODE_RESP, 2'($urandom_range(3)), $urandom(), 1'b1);
    endtask

    initial
    begin
        logic [15:0] limit_plan [6];
        logic        wide_plan [6];
        logic [1:0]  noise_mode;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_RETRY_LIMIT;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.mode = MODE_START;
        req_ch.resp_status = ST_OK;
        req_ch.resp_word = '0;
        limit_plan[0] = 16'd1;
        wide_plan[0] = 1'b1;
        limit_plan[1] = 16'd0;
        wide_plan[1] = 1'b0;
        limit_plan[2] = 16'd3;
        wide_plan[2] = 1'b1;
        limit_plan[3] = 16'hFFFF;
        wide_plan[3] = 1'b0;
        limit_plan[4] = 16'($urandom_range(2, 8));
        wide_plan[4] = 1'b1;
        limit_plan[5] = ($urandom_range(1) != 0) ? 16'hFFFF : 16'($urandom_range(2, 8));
        wide_plan[5] = 1'($urandom_range(1));
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, reset settings
        send_idle_pct = 19;
        recv_idle_pct = 66;
        feed(MODE_UNUSED, ST_BAD, 32'hFFFF_FFFF, 1'b1);
        feed(MODE_RESP, ST_OK, 32'h0, 1'b1);
        feed(MODE_TICK, ST_OK, 32'h0, 1'b1);
        feed(MODE_START, ST_OK, 32'h0, 1'b1);
        feed(MODE_RESP, ST_TIMEOUT, 32'h0, 1'b1);
        feed(MODE_START, ST_OK, 32'h0, 1'b1);
        feed(MODE_RESP, ST_CRC, 32'hFFFF_FFFF, 1'b1);
        feed(MODE_START, ST_OK, 32'h0, 1'b1);
        feed(MODE_RESP, ST_BAD, 32'h0, 1'b1);
        feed(MODE_START, ST_BAD, 32'hFFFF_FFFF, 1'b1);
        feed(MODE_RESP, ST_OK, 32'h0, 1'b1);
        feed(MODE_RESP, ST_TIMEOUT, 32'h0, 1'b1);
        feed(MODE_RESP, ST_CRC, 32'h0, 1'b1);
        feed(MODE_RESP, ST_CRC, 32'h7FFF_FFFF, 1'b1);
        feed(MODE_RESP, ST_OK, 32'hFFFF_FFFF, 1'b1);
        feed(MODE_UNUSED, ST_OK, 32'h0, 1'b1);
        feed(MODE_TICK, ST_OK, 32'h0, 1'b1);
        feed(MODE_RESP, ST_OK, 32'h0, 1'b1);
        feed(MODE_RESP, ST_BAD, 32'hFFFF_FFFF, 1'b1);
        feed(MODE_START, ST_OK, 32'h0, 1'b1);
        feed(MODE_RESP, ST_OK, 32'h0, 1'b1);
        feed(MODE_RESP, ST_OK, 32'h0, 1'b1);
        feed(MODE_RESP, ST_OK, 32'h0, 1'b1);
        feed(MODE_RESP, ST_OK, 32'hFFFF_FFFF, 1'b1);
        feed(MODE_RESP, ST_OK, 32'h0, 1'b1);
        feed(MODE_RESP, ST_OK, 32'hFFFF_FFFF, 1'b1);
        feed(MODE_START, ST_OK, 32'h0, 1'b1);

        for (int k = 0; k < 6; k++)
        begin
            case (k / 2)
                0:
                begin
                    send_idle_pct = 19;
                    recv_idle_pct = 66;
                end
                1:
                begin
                    send_idle_pct = 66;
                    recv_idle_pct = 19;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            apply_settings(limit_plan[k], wide_plan[k]);
            if (k == 4)
                hold_cycles = HOLD_CYCLES;
            while (items_sent < ITEM_TARGET * (k + 1) / 6)
            begin
                bring_up(1'b0);
                repeat ($urandom_range(0, 3))
                begin
                    case ($urandom_range(at_rest ? 2 : 1))
                        0: noise_mode = MODE_TICK;
                        1: noise_mode = MODE_UNUSED;
                        default: noise_mode = MODE_RESP;
                    endcase
                    feed(noise_mode, 2'($urandom_range(3)), $urandom(), 1'b1);
                end
            end
        end

        bring_up(1'b1);
        repeat (12)
            feed(2'($urandom_range(3)), 2'($urandom_range(3)), $urandom(), 1'b1);

        @(negedge clk);
        req_ch.valid = 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        $display("covered %0d input transfers and %0d checked results over %0d settings,",
                 items_sent, results_checked, settings_used);
        $display("with aborts, retry exhaustion, restarts, stray items and one full bring-up");
        if (mismatches == 0)
            $display("sd_card_init_sequencer test passed");
        else
            $display("sd_card_init_sequencer test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sdci_pkg.sv
rtl/sdci_req_if.sv
rtl/sdci_rsp_if.sv
rtl/sdci_step.sv
rtl/sd_card_init_sequencer.sv
tb/sdci_checker.sv
tb/testbench.sv
